// ===== design/mpfv_pkg.sv =====
// Shared types, codes and pattern helpers for the memory pattern fill/verify block.
// No dependencies; imported by mpfv_out_fifo and memory_pattern_fill_verify.
`timescale 1ns / 1ps
`default_nettype none

package mpfv_pkg;

  // defaults for top level parameters
  localparam int MEMORY_BYTES_DEFAULT = 4194304;
  localparam int OFFSET_BITS_DEFAULT  = 28;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BASE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_TOP        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_BOTTOM     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCESS_WIDTH      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_FROM_BOTTOM = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_USER_PATTERN      = 3'd5;

  // input commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // fill codes
  localparam logic [7:0] FILL_NONE   = 8'h00;
  localparam logic [7:0] FILL_ZEROS  = 8'h10;
  localparam logic [7:0] FILL_ONES   = 8'h20;
  localparam logic [7:0] FILL_33     = 8'h30;
  localparam logic [7:0] FILL_CC     = 8'h40;
  localparam logic [7:0] FILL_55     = 8'h50;
  localparam logic [7:0] FILL_AA     = 8'h60;
  localparam logic [7:0] FILL_USER   = 8'h70;
  localparam logic [7:0] FILL_ADDR16 = 8'h80;
  localparam logic [7:0] FILL_ADDR32 = 8'h90;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_GOOD       = 3'd0,
    ST_BAD_RANGE  = 3'd1,
    ST_VERIFY_ERR = 3'd2,
    ST_FILL_ERR   = 3'd3,
    ST_BAD_CODE   = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] data_value;
    logic        wide;
    logic [31:0] observed;
    status_t     status;
    logic        last;
  } result_t;

  // results produced by one input beat, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic code_ok(logic [7:0] code);
    return (code[3:0] == 4'h0) && (code >= FILL_ZEROS) && (code <= FILL_ADDR32);
  endfunction

  function automatic logic unit_wide(logic [7:0] code, logic access_width);
    logic w;
    w = access_width;
    if (code == FILL_ADDR16) w = 1'b0;
    else if (code == FILL_ADDR32) w = 1'b1;
    return w;
  endfunction

  function automatic logic [31:0] unit_mask(logic [31:0] v, logic wide);
    return wide ? v : {16'h0000, v[15:0]};
  endfunction

  function automatic logic [31:0] fill_pattern(logic [7:0] code, logic [31:0] addr,
                                               logic [31:0] user);
    logic [31:0] p;
    unique case (code)
      FILL_ZEROS:  p = 32'h00000000;
      FILL_ONES:   p = 32'hFFFFFFFF;
      FILL_33:     p = 32'h33333333;
      FILL_CC:     p = 32'hCCCCCCCC;
      FILL_55:     p = 32'h55555555;
      FILL_AA:     p = 32'hAAAAAAAA;
      FILL_USER:   p = user;
      FILL_ADDR16: p = {16'h0000, addr[15:0]};
      default:     p = addr;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/mpfv_out_fifo.sv =====
// Result queue: takes up to two result beats per cycle, delivers one per cycle unless pop_stall holds it.
// Depends on mpfv_pkg (result_t, push_t, queue sizing).
`timescale 1ns / 1ps
`default_nettype none

module mpfv_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire mpfv_pkg::push_t  push,
  output logic                  room_for_two,
  output logic                  head_valid,
  output mpfv_pkg::result_t     head,
  input  wire logic             pop_stall
);
  import mpfv_pkg::*;

  result_t            entries [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_plus1;

  assign head_valid   = (count != '0);
  assign room_for_two = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign pop          = head_valid && !pop_stall;
  assign head         = entries[rd_ptr];
  assign wr_ptr_plus1 = wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

// ===== design/memory_pattern_fill_verify.sv =====
// Top level of the memory pattern fill/verify sequencer.
// Depends on mpfv_pkg and mpfv_out_fifo.
`timescale 1ns / 1ps
`default_nettype none

// A start beat (command 0) with a fill code launches a test of the configured region: if a
// previous fill is remembered the region is first read back and checked against it, then the
// new pattern is written and read back unit by unit. Each read data beat (command 1) answers
// the last read request. Every input beat is taken into an input register and resolved against
// the sequencer state; it yields zero, one or two result beats into a four-entry result queue.
// The input side accepts one beat per cycle as long as the queue has room for two results;
// verify beats give one result each, fill beats give a write and a read, so the output port
// sets the pace during the fill pass. No clearing pass is needed after reset.
module memory_pattern_fill_verify
  import mpfv_pkg::*;
#(
  parameter int MEMORY_BYTES = mpfv_pkg::MEMORY_BYTES_DEFAULT,
  parameter int OFFSET_BITS  = mpfv_pkg::OFFSET_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mpfv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                      cfg_data,
  // input beats
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             command,
  input  wire logic [7:0]                       fill_code,
  input  wire logic [31:0]                      read_value,
  // result beats
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [1:0]                            request_kind,
  output logic [31:0]                           address,
  output logic [31:0]                           data_value,
  output logic                                  wide_access,
  output logic [31:0]                           observed_value,
  output logic [2:0]                            status,
  output logic                                  last
);

  localparam int OB = OFFSET_BITS;
  localparam logic [28:0] MEM_LIMIT = 29'(MEMORY_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_VERIFY = 3'b010,
    PH_FILL   = 3'b100
  } phase_t;

  // configuration
  logic [31:0] window_base;
  logic [27:0] region_top;
  logic [27:0] region_bottom;
  logic        access_width;
  logic        start_from_bottom;
  logic [31:0] user_pattern;

  // sequencer state
  phase_t        phase, phase_next;
  logic [OB-1:0] cur_off, cur_off_next;
  logic [7:0]    prev_code, prev_code_next;
  logic [7:0]    act_code, act_code_next;
  logic [31:0]   rem_user, rem_user_next;

  // input register
  logic        q_valid;
  logic        q_cmd;
  logic [7:0]  q_code;
  logic [31:0] q_rv;

  logic    process;
  logic    room_for_two;
  push_t   push;
  result_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base       <= '0;
      region_top        <= '0;
      region_bottom     <= '0;
      access_width      <= 1'b0;
      start_from_bottom <= 1'b0;
      user_pattern      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_BASE:       window_base       <= cfg_data;
        REG_REGION_TOP:        region_top        <= cfg_data[27:0];
        REG_REGION_BOTTOM:     region_bottom     <= cfg_data[27:0];
        REG_ACCESS_WIDTH:      access_width      <= cfg_data[0];
        REG_START_FROM_BOTTOM: start_from_bottom <= cfg_data[0];
        REG_USER_PATTERN:      user_pattern      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register refills whenever its beat is resolved in the same cycle
  assign process  = q_valid && room_for_two;
  assign in_stall = q_valid && !room_for_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      q_cmd  <= command;
      q_code <= fill_code;
      q_rv   <= read_value;
    end
  end

  // datapath helpers
  logic        ver_wide, fill_wide, new_wide;
  logic        cur_wide, req_wide;
  logic [7:0]  cur_code, req_code;
  logic [31:0] req_user;
  logic [31:0] addr_cur, addr_new;
  logic [31:0] exp_val, obs_val, wr_data;
  logic [28:0] cur_ext;
  logic        at_end;
  logic        range_bad;
  logic        use_start;
  logic        begin_fill_now;
  logic [OB-1:0] off_new;
  logic [27:0]   req_unit;

  assign ver_wide  = unit_wide(prev_code, access_width);
  assign fill_wide = unit_wide(act_code, access_width);
  assign new_wide  = unit_wide(q_code, access_width);

  assign cur_wide = (phase == PH_FILL) ? fill_wide : ver_wide;
  assign cur_code = (phase == PH_FILL) ? act_code : prev_code;
  assign cur_ext  = 29'(cur_off);
  assign addr_cur = window_base + 32'(cur_off);
  assign exp_val  = unit_mask(fill_pattern(cur_code, addr_cur, rem_user), cur_wide);
  assign obs_val  = unit_mask(q_rv, cur_wide);

  always_comb begin
    if (start_from_bottom) begin
      at_end = cur_ext < ({1'b0, region_top} + (cur_wide ? 29'd4 : 29'd2));
    end else begin
      at_end = (cur_ext + (cur_wide ? 29'd8 : 29'd4)) > {1'b0, region_bottom};
    end
  end

  assign range_bad = ({1'b0, region_top} >= MEM_LIMIT) ||
                     ({1'b0, region_bottom} > MEM_LIMIT) ||
                     ({1'b0, region_bottom} < ({1'b0, region_top} + 29'd4));

  // what the next request looks like, for whichever branch ends up issuing one
  always_comb begin
    use_start      = 1'b0;
    begin_fill_now = 1'b0;
    req_wide       = cur_wide;
    req_code       = act_code;
    if (phase == PH_IDLE) begin
      use_start = 1'b1;
      if (prev_code == FILL_NONE) begin
        begin_fill_now = 1'b1;
        req_wide       = new_wide;
        req_code       = q_code;
      end else begin
        req_wide = ver_wide;
      end
    end else if (phase == PH_VERIFY && at_end) begin
      use_start      = 1'b1;
      begin_fill_now = 1'b1;
      req_wide       = fill_wide;
    end
  end

  assign req_user = begin_fill_now ? user_pattern : rem_user;
  assign req_unit = req_wide ? 28'd4 : 28'd2;

  always_comb begin
    if (use_start) begin
      off_new = start_from_bottom ? OB'(region_bottom - req_unit) : OB'(region_top);
    end else if (start_from_bottom) begin
      off_new = cur_off - OB'(req_unit);
    end else begin
      off_new = cur_off + OB'(req_unit);
    end
  end

  assign addr_new = window_base + 32'(off_new);
  assign wr_data  = unit_mask(fill_pattern(req_code, addr_new, req_user), req_wide);

  // result builders
  function automatic result_t mk_done(status_t st, logic [31:0] a, logic [31:0] e,
                                      logic w, logic [31:0] o);
    result_t r;
    r.kind       = KIND_DONE;
    r.address    = a;
    r.data_value = e;
    r.wide       = w;
    r.observed   = o;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic result_t mk_req(kind_t k, logic [31:0] a, logic [31:0] d,
                                     logic w, logic l);
    result_t r;
    r.kind       = k;
    r.address    = a;
    r.data_value = d;
    r.wide       = w;
    r.observed   = '0;
    r.status     = ST_GOOD;
    r.last       = l;
    return r;
  endfunction

  always_comb begin
    phase_next     = phase;
    cur_off_next   = cur_off;
    prev_code_next = prev_code;
    act_code_next  = act_code;
    rem_user_next  = rem_user;
    push           = '0;
    if (process) begin
      if (q_cmd == CMD_START) begin
        if (phase == PH_IDLE) begin
          push.count = 2'd1;
          priority if (range_bad ||
                       (prev_code != FILL_NONE && !code_ok(prev_code))) begin
            push.r0 = mk_done(ST_BAD_RANGE, '0, '0, 1'b0, '0);
          end else if (!code_ok(q_code)) begin
            push.r0 = mk_done(ST_BAD_CODE, '0, '0, 1'b0, '0);
          end else if (begin_fill_now) begin
            act_code_next = q_code;
            rem_user_next = user_pattern;
            phase_next    = PH_FILL;
            cur_off_next  = off_new;
            push.count    = 2'd2;
            push.r0       = mk_req(KIND_WRITE, addr_new, wr_data, req_wide, 1'b0);
            push.r1       = mk_req(KIND_READ, addr_new, '0, req_wide, 1'b1);
          end else begin
            act_code_next = q_code;
            phase_next    = PH_VERIFY;
            cur_off_next  = off_new;
            push.r0       = mk_req(KIND_READ, addr_new, '0, req_wide, 1'b1);
          end
        end
      end else if (phase != PH_IDLE) begin
        if (obs_val != exp_val) begin
          prev_code_next = FILL_NONE;
          phase_next     = PH_IDLE;
          push.count     = 2'd1;
          push.r0 = mk_done((phase == PH_FILL) ? ST_FILL_ERR : ST_VERIFY_ERR,
                            addr_cur, exp_val, cur_wide, obs_val);
        end else if (phase == PH_FILL && at_end) begin
          prev_code_next = act_code;
          phase_next     = PH_IDLE;
          push.count     = 2'd1;
          push.r0        = mk_done(ST_GOOD, '0, '0, 1'b0, '0);
        end else if (phase == PH_FILL || begin_fill_now) begin
          if (begin_fill_now) begin
            rem_user_next = user_pattern;
          end
          phase_next   = PH_FILL;
          cur_off_next = off_new;
          push.count   = 2'd2;
          push.r0      = mk_req(KIND_WRITE, addr_new, wr_data, req_wide, 1'b0);
          push.r1      = mk_req(KIND_READ, addr_new, '0, req_wide, 1'b1);
        end else begin
          cur_off_next = off_new;
          push.count   = 2'd1;
          push.r0      = mk_req(KIND_READ, addr_new, '0, req_wide, 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      cur_off   <= '0;
      prev_code <= FILL_NONE;
      act_code  <= FILL_NONE;
      rem_user  <= '0;
    end else begin
      phase     <= phase_next;
      cur_off   <= cur_off_next;
      prev_code <= prev_code_next;
      act_code  <= act_code_next;
      rem_user  <= rem_user_next;
    end
  end

  mpfv_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .head_valid   (out_valid),
    .head         (head),
    .pop_stall    (out_stall)
  );

  assign request_kind   = head.kind;
  assign address        = head.address;
  assign data_value     = head.data_value;
  assign wide_access    = head.wide;
  assign observed_value = head.observed;
  assign status         = head.status;
  assign last           = head.last;

endmodule

`default_nettype wire
